[hdl/rcc_pkg.sv]
`timescale 1ns / 1ps

package rcc_pkg;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MISSING   = 2'd1;
    localparam logic [1:0] ST_BAD_RANGE = 2'd2;
    localparam logic [1:0] ST_ORDER     = 2'd3;

    // range phase codes
    localparam logic [1:0] PH_LITERAL   = 2'd0;
    localparam logic [1:0] PH_RANGE_OK  = 2'd1;
    localparam logic [1:0] PH_RANGE_END = 2'd2;
    localparam logic [1:0] PH_SHORT     = 2'd3;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned NUM_WORDS = 4;
    localparam int unsigned MAP_W   = WORD_W * NUM_WORDS;

    typedef logic [MAP_W-1:0] t_map;

    typedef struct packed {
        t_map       bits;
        logic       inv;
        logic [1:0] phase;
        logic [7:0] low;
        logic [7:0] prev;
        logic       esc;
        logic       hyph;
        logic       first;
    } t_state;

    typedef struct packed {
        logic       ok;
        logic       err;
        logic [1:0] status;
    } t_emit;

    localparam t_state CLASS_CLEAR = '{
        bits:  '0,
        inv:   1'b0,
        phase: PH_LITERAL,
        low:   8'd0,
        prev:  8'd0,
        esc:   1'b0,
        hyph:  1'b0,
        first: 1'b1
    };

endpackage

[hdl/rcc_step.sv]
`timescale 1ns / 1ps

module rcc_step (
    input  rcc_pkg::t_state i_state,
    input  logic [7:0]      i_byte,
    input  logic            i_start,
    input  logic            i_allow_empty,
    output rcc_pkg::t_state o_next,
    output rcc_pkg::t_emit  o_emit,
    output rcc_pkg::t_map   o_bitmap
);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    localparam rcc_pkg::t_map DIGIT_SET = {192'd0, 64'h03FF000000000000};
    localparam rcc_pkg::t_map SPACE_SET =
        {64'd0, 64'h0000000100000000, 64'd0, 64'h0000000100003E00};
    localparam rcc_pkg::t_map WORD_SET  =
        {128'd0, 64'h07FFFFFE87FFFFFE, 64'h03FF000000000000};

    // range close when low > c
    function automatic logic order_err(input rcc_pkg::t_state s, input logic [7:0] c);
        order_err = (s.phase == rcc_pkg::PH_RANGE_END) && (s.low > c);
    endfunction

    function automatic rcc_pkg::t_state add_char(input rcc_pkg::t_state s,
                                                 input logic [7:0] c);
        rcc_pkg::t_state r;
        r = s;
        if (s.phase == rcc_pkg::PH_RANGE_END) begin
            for (int i = 0; i < rcc_pkg::MAP_W; i++) begin
                if ((8'(i) >= s.low) && (8'(i) <= c)) r.bits[i] = 1'b1;
            end
            r.phase = rcc_pkg::PH_LITERAL;
        end else begin
            r.bits[c] = 1'b1;
            r.phase   = rcc_pkg::PH_RANGE_OK;
        end
        r.prev = c;
        add_char = r;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] c);
        case (c)
            8'h30:   esc_map = 8'd0;   // \0
            8'h62:   esc_map = 8'd8;   // \b
            8'h74:   esc_map = 8'd9;   // \t
            8'h6E:   esc_map = 8'd10;  // \n
            8'h76:   esc_map = 8'd11;  // \v
            8'h66:   esc_map = 8'd12;  // \f
            8'h72:   esc_map = 8'd13;  // \r
            default: esc_map = c;
        endcase
    endfunction

    rcc_pkg::t_state s;
    logic            done;
    logic [7:0]      lit;

    always_comb begin
        s      = i_state;
        done   = 1'b0;
        lit    = esc_map(i_byte);
        o_emit = '{ok: 1'b0, err: 1'b0, status: rcc_pkg::ST_OK};

        if (i_start) begin
            s = rcc_pkg::CLASS_CLEAR;
            if (i_byte == CH_CARET) begin
                s.inv = 1'b1;
                done  = 1'b1;
            end
        end

        // held hyphen resolves before this byte is handled
        if (!done && s.hyph) begin
            s.hyph = 1'b0;
            if (i_byte != CH_RBRACK && s.phase == rcc_pkg::PH_RANGE_OK) begin
                s.phase = rcc_pkg::PH_RANGE_END;
                s.low   = s.prev;
            end else if (i_byte != CH_RBRACK && s.phase == rcc_pkg::PH_SHORT) begin
                o_emit.err    = 1'b1;
                o_emit.status = rcc_pkg::ST_BAD_RANGE;
                done          = 1'b1;
            end else if (order_err(s, CH_HYPHEN)) begin
                o_emit.err    = 1'b1;
                o_emit.status = rcc_pkg::ST_ORDER;
                done          = 1'b1;
            end else begin
                s = add_char(s, CH_HYPHEN);
            end
        end

        if (!done && s.esc) begin
            s.esc = 1'b0;
            done  = 1'b1;
            if (i_byte == CH_NUL) begin
                o_emit.err    = 1'b1;
                o_emit.status = rcc_pkg::ST_MISSING;
            end else if (i_byte == 8'h64 || i_byte == 8'h44 || i_byte == 8'h73 ||
                         i_byte == 8'h53 || i_byte == 8'h77 || i_byte == 8'h57) begin
                if (s.phase == rcc_pkg::PH_RANGE_END) begin
                    o_emit.err    = 1'b1;
                    o_emit.status = rcc_pkg::ST_BAD_RANGE;
                end else begin
                    case (i_byte)
                        8'h64:   s.bits = s.bits | DIGIT_SET;
                        8'h44:   s.bits = s.bits | ~DIGIT_SET;
                        8'h73:   s.bits = s.bits | SPACE_SET;
                        8'h53:   s.bits = s.bits | ~SPACE_SET;
                        8'h77:   s.bits = s.bits | WORD_SET;
                        default: s.bits = s.bits | ~WORD_SET;
                    endcase
                    s.phase = rcc_pkg::PH_SHORT;
                end
            end else if (order_err(s, lit)) begin
                o_emit.err    = 1'b1;
                o_emit.status = rcc_pkg::ST_ORDER;
            end else begin
                s = add_char(s, lit);
            end
        end

        if (!done) begin
            if (i_byte == CH_NUL) begin
                o_emit.err    = 1'b1;
                o_emit.status = rcc_pkg::ST_MISSING;
            end else if (i_byte == CH_RBRACK && (!s.first || i_allow_empty)) begin
                o_emit.ok = 1'b1;
            end else begin
                s.first = 1'b0;
                if (i_byte == CH_BSLASH) begin
                    s.esc = 1'b1;
                end else if (i_byte == CH_HYPHEN) begin
                    s.hyph = 1'b1;
                end else if (order_err(s, i_byte)) begin
                    o_emit.err    = 1'b1;
                    o_emit.status = rcc_pkg::ST_ORDER;
                end else begin
                    s = add_char(s, i_byte);
                end
            end
        end

        o_bitmap = s.inv ? ~s.bits : s.bits;
        o_next   = (o_emit.ok || o_emit.err) ? rcc_pkg::CLASS_CLEAR : s;
    end

endmodule

[hdl/regex_char_class_compiler.sv]
`timescale 1ns / 1ps
// Latency: the first result beat is presented the cycle after the byte that causes it.
// Throughput: one pattern byte per cycle; a closing bracket yields four beats, an
//   error one beat. A byte that would start a new result group is stalled while
//   the previous group is still draining from the output buffer.
// Reset: synchronous, active low on i_rst_n; clears the config bit, the class state
//   and the output buffer's busy flag and word counter; the payload is not reset.

module regex_char_class_compiler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_pattern_byte,
    input  logic        i_class_start,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [1:0]  o_word_index,
    output logic [63:0] o_bitmap_word,
    output logic        o_last
);

    // config register
    logic r_allow_empty_class;

    // class state, updated on every accepted beat
    rcc_pkg::t_state r_state;
    rcc_pkg::t_state n_state;

    // step logic results
    rcc_pkg::t_emit  step_emit;
    rcc_pkg::t_map   step_bitmap;

    // output buffer: one bitmap snapshot or one error, drained a beat at a time
    logic            r_busy;
    logic            r_err;
    logic [1:0]      r_status;
    logic [1:0]      r_cnt;
    rcc_pkg::t_map   r_obuf;

    logic in_accept;
    logic out_accept;
    logic gen;

    rcc_step u_step (
        .i_state       (r_state),
        .i_byte        (i_pattern_byte),
        .i_start       (i_class_start),
        .i_allow_empty (r_allow_empty_class),
        .o_next        (n_state),
        .o_emit        (step_emit),
        .o_bitmap      (step_bitmap)
    );

    assign gen        = step_emit.ok || step_emit.err;
    // only a byte that produces results waits on the buffer
    assign o_stall    = r_busy && gen;
    assign in_accept  = i_valid && !o_stall;
    assign out_accept = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_empty_class <= 1'b0;
        end else if (i_cfg_we) begin
            r_allow_empty_class <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcc_pkg::CLASS_CLEAR;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 2'd0;
        end else if (in_accept && gen) begin
            r_busy <= 1'b1;
            r_cnt  <= 2'd0;
        end else if (out_accept) begin
            if (o_last) begin
                r_busy <= 1'b0;
            end
            r_cnt <= r_cnt + 2'd1;
        end
    end

    // payload of the buffer, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept && gen) begin
            r_err    <= step_emit.err;
            r_status <= step_emit.status;
            r_obuf   <= step_bitmap;
        end
    end

    assign o_valid       = r_busy;
    assign o_status      = r_err ? r_status : rcc_pkg::ST_OK;
    assign o_word_index  = r_cnt;
    assign o_bitmap_word = r_err ? 64'd0 : r_obuf[r_cnt*rcc_pkg::WORD_W +: rcc_pkg::WORD_W];
    assign o_last        = r_err || (r_cnt == 2'(rcc_pkg::NUM_WORDS - 1));

    // an error beat is a lone word 0 marked last
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != rcc_pkg::ST_OK) |-> (o_last && o_word_index == 2'd0))
        else $error("error beat not single");

    // bitmap words leave in order
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_accept && !o_last) |=> (o_valid && o_word_index == $past(o_word_index) + 2'd1))
        else $error("bitmap word skipped");

    // a new group is never loaded over one still in the buffer
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && gen) |-> !r_busy)
        else $error("output buffer overrun");

endmodule

[verif/regex_char_class_compiler_test.sv]
`timescale 1ns / 1ps

// Bracket-class compiler bench: random byte streams (mostly well-formed
// classes, some noise and broken classes) go in on the pattern channel; a
// local predictor rebuilds the 256-bit class map and queues the expected
// result beats, which the monitor checks in order.
module regex_char_class_compiler_test;

    localparam int unsigned CYCLE_LIMIT = 200000;
    // Idle cycles before a config write; a trailing byte may still be in flight.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_BYTES_PER_PHASE = 105;
    localparam int unsigned NUM_PHASES = 4;
    localparam int unsigned MAX_PRINTED = 40;

    // receiver stall patterns
    localparam int STALL_NONE   = 0;
    localparam int STALL_RANDOM = 1;
    localparam int STALL_BURSTS = 2;

    // shorthand escape sets, word 3 on the left
    localparam logic [255:0] DIGIT_SET = {192'd0, 64'h03FF000000000000};
    localparam logic [255:0] SPACE_SET = {64'h0, 64'h0000000100000000,
                                          64'h0, 64'h0000000100003E00};
    localparam logic [255:0] WORD_SET  = {128'd0, 64'h07FFFFFE87FFFFFE,
                                          64'h03FF000000000000};

    typedef struct {
        logic [7:0] pat;
        logic       start;
        logic       drain;   // sender holds this beat until all results are in
    } t_pat_item;

    typedef struct {
        logic [1:0]  status;
        logic [1:0]  widx;
        logic [63:0] word;
        logic        last;
    } t_map_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_data = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_pattern_byte = 8'd0;
    logic        i_class_start = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [1:0]  o_word_index;
    logic [63:0] o_bitmap_word;
    logic        o_last;

    regex_char_class_compiler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pattern_byte (i_pattern_byte),
        .i_class_start  (i_class_start),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_word_index   (o_word_index),
        .o_bitmap_word  (o_bitmap_word),
        .o_last         (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the class being compiled.
    // ------------------------------------------------------------------
    logic [255:0] class_map;
    logic         negated;
    logic [1:0]   phase;
    logic [7:0]   range_lo;
    logic [7:0]   last_ch;
    logic         esc_wait;
    logic         hyph_wait;
    logic         at_first;
    logic         empty_ok = 1'b0;

    t_map_word    expected_words[$];
    t_pat_item    pending[$];

    int unsigned  mismatches = 0;
    int unsigned  byte_count = 0;
    bit           byte_taken = 1'b0;
    bit           fresh_class = 1'b0;
    bit           drain_next = 1'b0;
    int           stall_mode = STALL_NONE;
    int unsigned  stall_run = 0;
    int unsigned  burst_left = 1;
    int unsigned  gap_left = 0;

    task automatic flag_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic clear_class_state();
        class_map = '0;
        negated   = 1'b0;
        phase     = rcc_pkg::PH_LITERAL;
        range_lo  = 8'd0;
        last_ch   = 8'd0;
        esc_wait  = 1'b0;
        hyph_wait = 1'b0;
        at_first  = 1'b1;
    endtask

    // Error: a single beat carrying only the status, then the class is dropped.
    task automatic emit_error(input logic [1:0] st);
        t_map_word w;
        w.status = st;
        w.widx   = 2'd0;
        w.word   = 64'd0;
        w.last   = 1'b1;
        expected_words.push_back(w);
        clear_class_state();
    endtask

    // Adds one member, or closes an open range. Returns the status.
    function automatic logic [1:0] add_member(input logic [7:0] c);
        int i;
        if (phase == rcc_pkg::PH_RANGE_END) begin
            if (range_lo > c)
                return rcc_pkg::ST_ORDER;
            for (i = range_lo; i <= c; i++)
                class_map[i] = 1'b1;
            phase = rcc_pkg::PH_LITERAL;
        end else begin
            class_map[c] = 1'b1;
            phase = rcc_pkg::PH_RANGE_OK;
        end
        last_ch = c;
        return rcc_pkg::ST_OK;
    endfunction

    task automatic compile_byte(input logic [7:0] b_in, input logic start);
        logic [7:0]   b;
        logic [1:0]   st;
        logic [255:0] m;
        logic [255:0] sh;
        logic         shorthand;
        t_map_word    w;
        b = b_in;

        // class start drops anything in progress; only here is a caret special
        if (start) begin
            clear_class_state();
            if (b == "^") begin
                negated = 1'b1;
                return;
            end
        end

        // resolve a held hyphen before looking at this byte
        if (hyph_wait) begin
            hyph_wait = 1'b0;
            if (b != "]" && phase == rcc_pkg::PH_RANGE_OK) begin
                phase    = rcc_pkg::PH_RANGE_END;
                range_lo = last_ch;
            end else if (b != "]" && phase == rcc_pkg::PH_SHORT) begin
                emit_error(rcc_pkg::ST_BAD_RANGE);
                return;
            end else begin
                st = add_member("-");
                if (st != rcc_pkg::ST_OK) begin
                    emit_error(st);
                    return;
                end
            end
        end

        if (esc_wait) begin
            esc_wait = 1'b0;
            if (b == 8'h00) begin
                emit_error(rcc_pkg::ST_MISSING);
                return;
            end
            shorthand = (b == "d" || b == "D" || b == "s" || b == "S" ||
                         b == "w" || b == "W");
            if (shorthand) begin
                if (phase == rcc_pkg::PH_RANGE_END) begin
                    emit_error(rcc_pkg::ST_BAD_RANGE);
                    return;
                end
                sh = (b == "d" || b == "D") ? DIGIT_SET :
                     (b == "s" || b == "S") ? SPACE_SET : WORD_SET;
                // upper case letters have bit 5 clear: negated shorthand
                if (!b[5])
                    class_map = class_map | ~sh;
                else
                    class_map = class_map | sh;
                phase = rcc_pkg::PH_SHORT;
                return;
            end
            case (b)
                "0": b = 8'h00;
                "b": b = 8'h08;
                "t": b = 8'h09;
                "n": b = 8'h0A;
                "v": b = 8'h0B;
                "f": b = 8'h0C;
                "r": b = 8'h0D;
                default: ;
            endcase
            st = add_member(b);
            if (st != rcc_pkg::ST_OK)
                emit_error(st);
            return;
        end

        if (b == 8'h00) begin
            emit_error(rcc_pkg::ST_MISSING);
            return;
        end

        // closing bracket: four words, low quarter first
        if (b == "]" && (!at_first || empty_ok)) begin
            m = negated ? ~class_map : class_map;
            for (int k = 0; k < 4; k++) begin
                w.status = rcc_pkg::ST_OK;
                w.widx   = k[1:0];
                w.word   = m[64*k +: 64];
                w.last   = (k == 3);
                expected_words.push_back(w);
            end
            clear_class_state();
            return;
        end

        at_first = 1'b0;
        if (b == "\\") begin
            esc_wait = 1'b1;
            return;
        end
        if (b == "-") begin
            hyph_wait = 1'b1;
            return;
        end
        st = add_member(b);
        if (st != rcc_pkg::ST_OK)
            emit_error(st);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [7:0] b, input logic start);
        t_pat_item it;
        it.pat   = b;
        it.start = start;
        it.drain = drain_next;
        pending.push_back(it);
        drain_next = 1'b0;
        byte_count++;
    endtask

    task automatic queue_text(input string s, input logic start);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i], start && (i == 0));
    endtask

    // class body byte; the first one after a restart carries class_start
    task automatic put(input logic [7:0] b);
        queue_byte(b, fresh_class);
        fresh_class = 1'b0;
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == "]" || c == "\\" || c == "-");
        return c;
    endfunction

    function automatic logic [7:0] escape_char();
        string esc_list;
        string odd_list;
        esc_list = "dDsSwW0btnvfr";
        odd_list = "]-\\^";
        case ($urandom_range(0, 3))
            0, 1:    return esc_list[$urandom_range(0, esc_list.len() - 1)];
            2:       return 8'($urandom_range(1, 255));
            default: return odd_list[$urandom_range(0, odd_list.len() - 1)];
        endcase
    endfunction

    task automatic put_endpoint(input logic [7:0] c);
        if ($urandom_range(0, 4) == 0)
            put("\\");
        put(c);
    endtask

    // One well-formed class with random content, sometimes with a flaw.
    task automatic queue_class();
        int         n;
        int         kind;
        logic [7:0] a;
        logic [7:0] z;
        logic [7:0] t;
        string      sh_list;
        sh_list = "dDsSwW";
        fresh_class = 1'b1;
        if ($urandom_range(0, 3) == 0)
            put("^");
        n = $urandom_range(0, 6);
        for (int j = 0; j < n; j++) begin
            kind = $urandom_range(0, 19);
            if (kind < 8) begin
                put(plain_char());
            end else if (kind < 12) begin
                put("\\");
                put(escape_char());
            end else if (kind < 17) begin
                a = plain_char();
                z = plain_char();
                // mostly ordered; the rest should give the order error
                if (a > z && $urandom_range(0, 7) != 0) begin
                    t = a;
                    a = z;
                    z = t;
                end
                put_endpoint(a);
                put("-");
                put_endpoint(z);
            end else if (kind == 17) begin
                put("-");
            end else if (kind == 18) begin
                // hyphen before a shorthand: range to a class is invalid
                put("-");
                put("\\");
                put(sh_list[$urandom_range(0, 5)]);
            end else begin
                case ($urandom_range(0, 2))
                    0:       put(8'h00);
                    1:       fresh_class = 1'b1;   // restart mid-class
                    default: begin
                        put("\\");
                        put(8'h00);
                    end
                endcase
            end
        end
        put("]");
    endtask

    task automatic queue_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int j = 0; j < n; j++)
            queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    endtask

    task automatic wait_for_idle();
        @(posedge i_clk);
        while (pending.size() != 0 || i_valid || expected_words.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_allow_empty(input logic v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        empty_ok = v;
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps. A beat stays put
    // until it is taken; valid is never a function of o_stall.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : pattern_driver
        logic      nv;
        t_pat_item it;
        if (i_rst_n && (!i_valid || byte_taken)) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending.size() > 0 &&
                         !(pending[0].drain && expected_words.size() > 0)) begin
                it = pending.pop_front();
                i_pattern_byte <= it.pat;
                i_class_start  <= it.start;
                nv = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            i_valid <= nv;
        end
    end

    // Receiver back-pressure; pattern changes per phase.
    always @(negedge i_clk) begin : result_stall
        logic ns;
        ns = 1'b0;
        if (stall_run > 0) begin
            stall_run--;
            ns = 1'b1;
        end else begin
            case (stall_mode)
                STALL_RANDOM: ns = ($urandom_range(0, 2) == 0);
                STALL_BURSTS: begin
                    if ($urandom_range(0, 7) == 0) begin
                        stall_run = $urandom_range(1, 8);
                        ns = 1'b1;
                    end
                end
                default: ns = 1'b0;
            endcase
        end
        i_stall <= ns;
    end

    // ------------------------------------------------------------------
    // Monitor: result beats are checked before this edge's input beat is
    // predicted, since a result never shows up in the same cycle.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_map_word e;
        byte_taken = (i_valid === 1'b1) && (o_stall === 1'b0);
        if (i_rst_n) begin
            if (o_valid === 1'b1 && i_stall === 1'b0) begin
                if (expected_words.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result beat, word %0d", o_word_index));
                end else begin
                    e = expected_words.pop_front();
                    if (o_status !== e.status)
                        flag_mismatch($sformatf("status %0d, want %0d", o_status, e.status));
                    if (o_word_index !== e.widx)
                        flag_mismatch($sformatf("word index %0d, want %0d",
                                                o_word_index, e.widx));
                    if (o_bitmap_word !== e.word)
                        flag_mismatch($sformatf("word %0d bitmap %h, want %h",
                                                e.widx, o_bitmap_word, e.word));
                    if (o_last !== e.last)
                        flag_mismatch($sformatf("last %b, want %b on word %0d",
                                                o_last, e.last, e.widx));
                end
            end
            if (byte_taken)
                compile_byte(i_pattern_byte, i_class_start);
        end
    end

    // Hard stop on a hang.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequencer: reset, then phases alternating the empty-class setting.
    // ------------------------------------------------------------------
    initial begin : sequencer
        int unsigned target;
        clear_class_state();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_for_idle();
            write_allow_empty(ph[0]);
            @(posedge i_clk);
            case (ph)
                0:       stall_mode = STALL_RANDOM;
                1:       stall_mode = STALL_BURSTS;
                2:       stall_mode = STALL_NONE;
                default: stall_mode = STALL_RANDOM;
            endcase

            if (ph == 0) begin
                // leading close bracket is literal, caret inverts
                queue_text("^]a-z]", 1'b1);
                // hyphen right after a shorthand: invalid range
                queue_text("\\d\\S-x", 1'b1);
                // reversed range
                queue_text("z-a", 1'b1);
                // escaped zero to 0xFF: every byte
                queue_text("\\0-", 1'b1);
                queue_byte(8'hFF, 1'b0);
                queue_text("]", 1'b0);
                // escape followed by end of pattern
                queue_text("\\", 1'b1);
                queue_byte(8'h00, 1'b0);
                // hyphen before close bracket is literal
                queue_text("a-]", 1'b1);
            end else if (ph == 1) begin
                // empty class, and its inverse
                queue_text("]", 1'b1);
                queue_text("^]", 1'b1);
                // shorthand as range end
                queue_text("a-\\d", 1'b1);
            end

            // first random class of each phase waits for a full drain
            target = byte_count + RANDOM_BYTES_PER_PHASE;
            drain_next = 1'b1;
            while (byte_count < target) begin
                if ($urandom_range(0, 9) == 0)
                    queue_noise();
                else
                    queue_class();
                if ($urandom_range(0, 29) == 0)
                    drain_next = 1'b1;
            end
        end

        wait_for_idle();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/rcc_pkg.sv
hdl/rcc_step.sv
hdl/regex_char_class_compiler.sv
verif/regex_char_class_compiler_test.sv
